// File: rtl/mhms_pkg.sv
// Shared types and constants for the min-hash minimum selector.
`timescale 1ns / 1ps
`default_nettype none

package mhms_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned HASH_W  = 32;
    localparam int unsigned HBITS_W = 6;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // register index of hash_bits
    localparam logic [APB_ADDR_W-3:0] REG_HASH_BITS = '0;

    localparam logic [HBITS_W-1:0] HASH_BITS_RESET = HBITS_W'(20);

    // hash seed and the two terms of the first step that depend on the seed only
    localparam logic [HASH_W-1:0] HASH_SEED     = 32'hAAAA_AAAA;
    localparam logic [HASH_W-1:0] HASH_SEED_SHL = HASH_SEED << 7;
    localparam logic [HASH_W-1:0] HASH_MUL      = HASH_SEED >> 3;

    typedef struct packed {
        logic [ID_W-1:0]    feature_id;
        logic [VALUE_W-1:0] elem_value;
        logic [CODE_W-1:0]  proj_code;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] kept_value;
        logic [HASH_W-1:0]  min_hash;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/minhash_min_select_top.sv
// Top level of the min-hash minimum selector: hash pipeline, running minimum, APB register.
// An item marked last passes stage A, stage B and the result register before its result shows on m_item.
// Throughput: one item per cycle unless stalled; hash multiply and compare sit in separate stages.
// Stalls: only a last item waiting on a full result register holds the pipeline.
// Reset (aresetn low, synchronous): pipeline emptied, hash_bits back to 20,
// running minimum cleared and the next item starts a new vector.
`timescale 1ns / 1ps
`default_nettype none

module minhash_min_select_top (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // input items
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  mhms_pkg::in_item_t                   s_item,
    // result items
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output mhms_pkg::out_item_t                  m_item,
    // APB register port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [mhms_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [mhms_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mhms_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import mhms_pkg::*;

    // ---------------------------------------------------------------
    // Register file: a single register, hash_bits, at word index 0.
    // Byte offset bits of paddr are ignored.
    // ---------------------------------------------------------------
    logic [HBITS_W-1:0]      hash_bits_reg;
    logic [APB_ADDR_W-3:0]   reg_index;
    logic                    apb_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign apb_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_bits_reg <= HASH_BITS_RESET;
        end else if (apb_write && reg_index == REG_HASH_BITS) begin
            hash_bits_reg <= pwdata[HBITS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_HASH_BITS) begin
            prdata = APB_DATA_W'(hash_bits_reg);
        end
    end

    // Mask of kept hash bits; 32 and above keep the whole word.
    logic [HASH_W-1:0] hash_mask;
    logic [HASH_W:0]   mask_pow;

    assign mask_pow  = (HASH_W+1)'(1) << hash_bits_reg[4:0];
    assign hash_mask = hash_bits_reg[5] ? '1 : HASH_W'(mask_pow - (HASH_W+1)'(1));

    // ---------------------------------------------------------------
    // Pipeline control.
    // Stage A: input register. Stage B: first hash step registered.
    // Result register: kept min value and hash of a finished vector.
    // Only a last item in stage B needs a free result register; every
    // other item always moves on, so the pipeline stalls only then.
    // ---------------------------------------------------------------
    logic      a_vld_reg;
    in_item_t  a_item_reg;

    logic                b_vld_reg;
    logic [HASH_W-1:0]   b_h1_reg;
    logic [CODE_W-1:0]   b_code_reg;
    logic [VALUE_W-1:0]  b_value_reg;
    logic                b_last_reg;

    logic      m_valid_reg;
    out_item_t m_item_reg;

    logic out_free;
    logic b_fire;
    logic b_free;
    logic a_fire;
    logic s_fire;

    assign out_free = !m_valid_reg || m_ready;
    assign b_fire   = b_vld_reg && (!b_last_reg || out_free);
    assign b_free   = !b_vld_reg || b_fire;
    assign a_fire   = a_vld_reg && b_free;
    assign s_ready  = !a_vld_reg || a_fire;
    assign s_fire   = s_valid && s_ready;

    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // ---------------------------------------------------------------
    // Hash, first step: the seed is fixed, so this is one multiply of
    // the feature id by a constant plus an xor with a constant.
    // ---------------------------------------------------------------
    logic [HASH_W-1:0] h1;

    assign h1 = HASH_SEED ^ HASH_SEED_SHL ^ (a_item_reg.feature_id * HASH_MUL);

    // Hash, second step: shift, add, xor, invert; then mask and compare.
    logic [HASH_W-1:0] h2;
    logic [HASH_W-1:0] h_masked;

    assign h2       = b_h1_reg ^ ~(((b_h1_reg << 11) + b_code_reg) ^ (b_h1_reg >> 5));
    assign h_masked = h2 & hash_mask;

    // ---------------------------------------------------------------
    // Running minimum: first item of a vector loads without compare;
    // strict less-than keeps the earlier item on a tie.
    // ---------------------------------------------------------------
    logic                start_reg;
    logic [HASH_W-1:0]   best_hash_reg;
    logic [VALUE_W-1:0]  best_value_reg;
    logic                take;
    logic [HASH_W-1:0]   best_hash_next;
    logic [VALUE_W-1:0]  best_value_next;

    assign take            = start_reg || (h_masked < best_hash_reg);
    assign best_hash_next  = take ? h_masked    : best_hash_reg;
    assign best_value_next = take ? b_value_reg : best_value_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            start_reg      <= 1'b1;
            best_hash_reg  <= '0;
            best_value_reg <= '0;
        end else begin
            if (s_ready) begin
                a_vld_reg <= s_valid;
            end
            if (b_free) begin
                b_vld_reg <= a_fire;
            end
            if (b_fire) begin
                best_hash_reg  <= best_hash_next;
                best_value_reg <= best_value_next;
                start_reg      <= b_last_reg;
            end
            if (b_fire && b_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_item_reg <= s_item;
        end
        if (a_fire) begin
            b_h1_reg    <= h1;
            b_code_reg  <= a_item_reg.proj_code;
            b_value_reg <= a_item_reg.elem_value;
            b_last_reg  <= a_item_reg.last;
        end
        if (b_fire && b_last_reg) begin
            m_item_reg.kept_value <= best_value_next;
            m_item_reg.min_hash   <= best_hash_next;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a last item never overwrites a result still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_fire && b_last_reg) |-> out_free)
        else $error("result register overwritten");

    // a last item opens a new vector, any other item continues it
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_fire |=> (start_reg == $past(b_last_reg)))
        else $error("vector start flag wrong");

    // within a vector the kept hash never grows
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_fire && !start_reg) |=> (best_hash_reg <= $past(best_hash_reg)))
        else $error("running minimum increased");

    // after an update with no APB write in the same cycle, the kept hash fits the configured width
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_fire && !apb_write) |=> ((best_hash_reg & ~hash_mask) == '0))
        else $error("kept hash exceeds mask");

endmodule

`default_nettype wire
